// File: rtl/lfmcg_pkg.sv
// Shared types, constants and the quarter-wave sine table of the chirp generator.
// Used by every module of the block; depends on nothing.
package lfmcg_pkg;

    // Widths of the frame counter and of the phase-to-table index.
    localparam int COUNT_BITS   = 16;
    localparam int TABLE_BITS   = 10;
    localparam int QUARTER      = 1 << (TABLE_BITS - 2);
    localparam int QIDX_BITS    = TABLE_BITS - 1;
    localparam int PHASE_BITS   = 32;
    localparam int SAMPLE_BITS  = 16;
    localparam int AMP_BITS     = 15;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 32;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_AMPLITUDE       = 3'd0,
        REG_START_INCREMENT = 3'd1,
        REG_INCREMENT_STEP  = 3'd2,
        REG_CHIRP_LENGTH    = 3'd3,
        REG_SHIFT_SAMPLES   = 3'd4,
        REG_FRAME_LENGTH    = 3'd5
    } t_cfg_reg;

    // Configuration register set.
    typedef struct packed {
        logic [AMP_BITS-1:0]   amplitude;
        logic [PHASE_BITS-1:0] start_increment;
        logic [PHASE_BITS-1:0] increment_step;
        logic [15:0]           chirp_length;
        logic [15:0]           shift_samples;
        logic [15:0]           frame_length;
    } t_cfg;

    // One tick as handed from the phase stage to the sample stage.
    typedef struct packed {
        logic                   in_window;
        logic                   active;
        logic                   last;
        logic [SAMPLE_BITS-1:0] index;
        logic [TABLE_BITS-1:0]  table_idx;
    } t_tick;

    typedef logic [AMP_BITS-1:0] t_unit_table [0:QUARTER];

    // Fixed-point constants of the polynomial sine evaluation (Q30).
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] DIVS [0:5]  = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

    // Unit sine in Q15 for a quarter-wave index in [0, QUARTER].
    function automatic logic [AMP_BITS-1:0] quarter_unit(input int unsigned r);
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] s;
        logic [63:0] u;
        x = (64'(r) * HALF_PI_Q30) >> (TABLE_BITS - 2);
        y = (x * x) >> 30;
        term = Q30_ONE;
        for (int k = 0; k < 6; k++) begin
            term = Q30_ONE - (((y * term) >> 30) / DIVS[k]);
        end
        s = (x * term) >> 30;
        u = (s + (64'd1 << 14)) >> 15;
        if (u > 64'd32767) begin
            u = 64'd32767;
        end
        return AMP_BITS'(u);
    endfunction

    // Whole quarter-wave table, built at elaboration.
    function automatic t_unit_table build_table();
        t_unit_table tab;
        for (int i = 0; i <= QUARTER; i++) begin
            tab[i] = quarter_unit(i);
        end
        return tab;
    endfunction

    localparam t_unit_table SINE_TABLE = build_table();

endpackage

// File: rtl/lfmcg_phase.sv
// Frame sequencer and quadratic phase accumulator of the chirp generator.
// Depends on lfmcg_pkg; registers one tick per transfer for the sample stage.
module lfmcg_phase (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic                i_start_req,
    input  lfmcg_pkg::t_cfg     i_cfg,
    output lfmcg_pkg::t_tick    o_tick
);
    import lfmcg_pkg::*;

    logic [COUNT_BITS-1:0] r_cnt;
    logic [PHASE_BITS-1:0] r_acc;
    logic [PHASE_BITS-1:0] r_step;
    logic                  r_running;
    t_tick                 r_tick;

    logic [COUNT_BITS-1:0] n_cnt;
    logic [PHASE_BITS-1:0] n_acc;
    logic [PHASE_BITS-1:0] n_step;
    logic                  n_running;
    t_tick                 n_tick;

    logic [COUNT_BITS-1:0] cnt_eff;
    logic [PHASE_BITS-1:0] acc_eff;
    logic [PHASE_BITS-1:0] step_eff;
    logic                  run_eff;
    logic [COUNT_BITS-1:0] flen;
    logic [COUNT_BITS-1:0] sh;
    logic [COUNT_BITS-1:0] clen;
    logic [COUNT_BITS-1:0] offset;
    logic                  is_last;
    logic                  in_win;

    // Next state for one tick; a start request first rewinds the frame.
    always_comb begin
        flen     = COUNT_BITS'(i_cfg.frame_length);
        sh       = COUNT_BITS'(i_cfg.shift_samples);
        clen     = COUNT_BITS'(i_cfg.chirp_length);
        cnt_eff  = i_start_req ? '0 : r_cnt;
        acc_eff  = i_start_req ? '0 : r_acc;
        step_eff = i_start_req ? i_cfg.start_increment : r_step;
        run_eff  = i_start_req | r_running;
        offset   = cnt_eff - sh;
        in_win   = (cnt_eff >= sh) && (offset < clen);
        is_last  = ((COUNT_BITS + 1)'(cnt_eff) + (COUNT_BITS + 1)'(1))
                   == (COUNT_BITS + 1)'(flen);

        n_cnt     = cnt_eff;
        n_acc     = acc_eff;
        n_step    = step_eff;
        n_running = 1'b0;
        n_tick    = '0;

        if (run_eff && (cnt_eff < flen)) begin
            n_cnt            = cnt_eff + COUNT_BITS'(1);
            n_running        = ~is_last;
            n_tick.active    = 1'b1;
            n_tick.last      = is_last;
            n_tick.index     = SAMPLE_BITS'(cnt_eff);
            n_tick.in_window = in_win;
            n_tick.table_idx = acc_eff[PHASE_BITS-1 -: TABLE_BITS];
            if (in_win) begin
                n_acc  = acc_eff + step_eff;
                n_step = step_eff + i_cfg.increment_step;
            end
        end
    end

    // State and tick register, loaded on each input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_acc     <= '0;
            r_step    <= '0;
            r_running <= 1'b0;
            r_tick    <= '0;
        end else if (i_accept) begin
            r_cnt     <= n_cnt;
            r_acc     <= n_acc;
            r_step    <= n_step;
            r_running <= n_running;
            r_tick    <= n_tick;
        end
    end

    assign o_tick = r_tick;

endmodule

// File: rtl/lfmcg_sample.sv
// Table lookup and amplitude scaling of the chirp samples, with the result register.
// Depends on lfmcg_pkg for the quarter-wave table and the tick type.
module lfmcg_sample (
    input  logic                                   i_clk,
    input  logic                                   i_load,
    input  lfmcg_pkg::t_tick                       i_tick,
    input  logic [lfmcg_pkg::AMP_BITS-1:0]         i_amplitude,
    output logic [lfmcg_pkg::SAMPLE_BITS-1:0]      o_i_sample,
    output logic [lfmcg_pkg::SAMPLE_BITS-1:0]      o_q_sample,
    output logic [lfmcg_pkg::SAMPLE_BITS-1:0]      o_sample_index,
    output logic                                   o_active,
    output logic                                   o_last
);
    import lfmcg_pkg::*;

    logic [SAMPLE_BITS-1:0] r_i_sample;
    logic [SAMPLE_BITS-1:0] r_q_sample;
    logic [SAMPLE_BITS-1:0] r_index;
    logic                   r_active;
    logic                   r_last;

    logic [TABLE_BITS-1:0]  cos_idx;
    logic [SAMPLE_BITS-1:0] sin_val;
    logic [SAMPLE_BITS-1:0] cos_val;

    // Amplitude-scaled sine of a full-circle table index, two's complement.
    function automatic logic [SAMPLE_BITS-1:0] scaled_sine(
        input logic [TABLE_BITS-1:0] t,
        input logic [AMP_BITS-1:0]   amp
    );
        logic [1:0]                quad;
        logic [QIDX_BITS-1:0]      r;
        logic [QIDX_BITS-1:0]      qidx;
        logic [AMP_BITS-1:0]       unit;
        logic [2*AMP_BITS:0]       prod;
        logic [SAMPLE_BITS-1:0]    mag;
        quad = t[TABLE_BITS-1 -: 2];
        r    = QIDX_BITS'(t[TABLE_BITS-3:0]);
        qidx = quad[0] ? (QIDX_BITS'(QUARTER) - r) : r;
        unit = SINE_TABLE[qidx];
        prod = (2*AMP_BITS+1)'(amp) * (2*AMP_BITS+1)'(unit)
               + (2*AMP_BITS+1)'(1 << 14);
        mag  = SAMPLE_BITS'(prod >> 15);
        return quad[1] ? (SAMPLE_BITS'(0) - mag) : mag;
    endfunction

    // Cosine is the sine a quarter turn ahead.
    always_comb begin
        cos_idx = i_tick.table_idx + TABLE_BITS'(QUARTER);
        sin_val = scaled_sine(i_tick.table_idx, i_amplitude);
        cos_val = scaled_sine(cos_idx, i_amplitude);
    end

    // Result register; samples outside the window are zero.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_i_sample <= i_tick.in_window ? cos_val : '0;
            r_q_sample <= i_tick.in_window ? sin_val : '0;
            r_index    <= i_tick.index;
            r_active   <= i_tick.active;
            r_last     <= i_tick.last;
        end
    end

    assign o_i_sample     = r_i_sample;
    assign o_q_sample     = r_q_sample;
    assign o_sample_index = r_index;
    assign o_active       = r_active;
    assign o_last         = r_last;

endmodule

// File: rtl/lfm_chirp_frame_generator_top.sv
// Top level of the linear FM chirp frame generator: stream handshake and settings.
// Depends on lfmcg_pkg, lfmcg_phase and lfmcg_sample.
//
//   Channel  Direction  Contents
//   s_axis   in         tdata[0] start_req (1 restarts the frame), tdata[7:1] zero
//   m_axis   out        tdata i_sample, q_sample, sample_index; tuser active; tlast last
//   cfg      in         wr_en, index 0..5, data up to 32 bits, no read-back
//
// Each input transfer yields one sample; one per clock unless the output stalls.
// The two stages are the phase/frame sequencer and the table lookup with the
// amplitude multiplier. Reset is synchronous and active low; it clears the settings,
// the frame state and both valid flags. A stalled output holds its sample; the input
// then takes at most one more transfer, into an empty phase stage, and waits.
module lfm_chirp_frame_generator_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  logic [7:0]                            i_s_axis_tdata,  // [0] start_req
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // [15:0] i_sample, [31:16] q_sample, [47:32] sample_index
    output logic [47:0]                           o_m_axis_tdata,
    output logic                                  o_m_axis_tuser,  // [0] active
    output logic                                  o_m_axis_tlast,
    input  logic                                  i_cfg_wr_en,
    input  logic [lfmcg_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [lfmcg_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import lfmcg_pkg::*;

    t_cfg  r_cfg;
    logic  r_tick_valid;
    logic  r_out_valid;

    logic  out_move;
    logic  tick_move;
    logic  accept;
    t_tick tick;

    logic [SAMPLE_BITS-1:0] i_sample;
    logic [SAMPLE_BITS-1:0] q_sample;
    logic [SAMPLE_BITS-1:0] sample_index;
    logic                   active;
    logic                   last;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_AMPLITUDE:       r_cfg.amplitude       <= i_cfg_data[AMP_BITS-1:0];
                REG_START_INCREMENT: r_cfg.start_increment <= i_cfg_data;
                REG_INCREMENT_STEP:  r_cfg.increment_step  <= i_cfg_data;
                REG_CHIRP_LENGTH:    r_cfg.chirp_length    <= i_cfg_data[15:0];
                REG_SHIFT_SAMPLES:   r_cfg.shift_samples   <= i_cfg_data[15:0];
                REG_FRAME_LENGTH:    r_cfg.frame_length    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Pipeline flow: each stage moves when the stage after it is empty or moving.
    assign out_move        = ~r_out_valid | i_m_axis_tready;
    assign tick_move       = r_tick_valid & out_move;
    assign o_s_axis_tready = ~r_tick_valid | out_move;
    assign accept          = i_s_axis_tvalid & o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_tick_valid <= i_s_axis_tvalid;
            end
            if (out_move) begin
                r_out_valid <= r_tick_valid;
            end
        end
    end

    lfmcg_phase u_phase (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_start_req (i_s_axis_tdata[0]),
        .i_cfg       (r_cfg),
        .o_tick      (tick)
    );

    lfmcg_sample u_sample (
        .i_clk          (i_clk),
        .i_load         (tick_move),
        .i_tick         (tick),
        .i_amplitude    (r_cfg.amplitude),
        .o_i_sample     (i_sample),
        .o_q_sample     (q_sample),
        .o_sample_index (sample_index),
        .o_active       (active),
        .o_last         (last)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {sample_index, q_sample, i_sample};
    assign o_m_axis_tuser  = active;
    assign o_m_axis_tlast  = last;

endmodule
